### sv/acl_pkg.sv
package acl_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam int IFACE_W = 2;
  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int TICK_W  = 64;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 64;

  // register select: paddr bit 3 (registers on 8-byte spacing)
  localparam logic REG_TTL    = 1'b0;
  localparam logic REG_EXPIRY = 1'b1;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic [IFACE_W-1:0] iface;
    logic [IP_W-1:0]    ip;
    logic [MAC_W-1:0]   mac;
    logic [TICK_W-1:0]  stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_RESP
  } state_t;

endpackage

### sv/acl_ram.sv
module acl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/arp_cache_lookup_update_top.sv
// ARP cache with round-robin replacement and TTL expiry.
// A request runs from accept to out_valid as a pipelined scan of the entry RAM, one
// compare per entry, then the update state (ST_ACT) and the result state (ST_RESP);
// a match at slot k ends the scan early.
// A new request is taken only once the previous result has been taken (in_ready in ST_IDLE).
// Reset (rst, synchronous): all entries invalid, replace pointer 0, ttl 0, expiry off.
module arp_cache_lookup_update_top import acl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // request
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [IFACE_W-1:0] iface_index,
  input  logic [IP_W-1:0]    ip_addr,
  input  logic [MAC_W-1:0]   new_mac,
  input  logic [TICK_W-1:0]  now_ticks,
  // result
  output logic               out_valid,
  input  logic               out_ready,
  output logic               found,
  output logic               expired,
  output logic [MAC_W-1:0]   mac_out,
  // config
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  state_t state, state_next;

  logic [TICK_W-1:0]  ttl_limit;
  logic               expiry_enable;

  logic               req_cmd;
  logic [IFACE_W-1:0] req_iface;
  logic [IP_W-1:0]    req_ip;
  logic [MAC_W-1:0]   req_mac;
  logic [TICK_W-1:0]  req_now;

  logic [ENTRIES-1:0] entry_valid;
  logic [IDX_W-1:0]   replace_ptr;

  logic [IDX_W-1:0]   issue_idx;
  logic [IDX_W-1:0]   chk_idx;
  logic               chk_pend;
  logic [IDX_W-1:0]   slot;
  logic               hit;
  logic [MAC_W-1:0]   hit_mac;
  logic [TICK_W-1:0]  hit_stamp;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;

  logic               key_match;
  logic [TICK_W-1:0]  age;
  logic               stale;
  logic               cfg_wr;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl_limit     <= '0;
      expiry_enable <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[3] == REG_TTL) begin
        ttl_limit <= pwdata;
      end else begin
        expiry_enable <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[3] == REG_TTL) begin
      prdata = ttl_limit;
    end else begin
      prdata = {{(PDATA_W-1){1'b0}}, expiry_enable};
    end
  end

  // entry store
  acl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES),
    .AW   (IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_entry  = entry_t'(ram_rdata);
  assign ram_raddr = issue_idx;

  // shared key compare, one entry per cycle
  assign key_match = chk_pend && entry_valid[chk_idx] &&
                     (rd_entry.iface == req_iface) && (rd_entry.ip == req_ip);

  assign age   = req_now - hit_stamp;
  assign stale = expiry_enable && (age > ttl_limit);

  always_comb begin
    ram_waddr       = hit ? slot : replace_ptr;
    ram_wdata.iface = req_iface;
    ram_wdata.ip    = req_ip;
    ram_wdata.mac   = req_mac;
    ram_wdata.stamp = expiry_enable ? req_now : '0;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    ram_we     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (key_match || (chk_pend && chk_idx == LAST_IDX)) begin
          state_next = ST_ACT;
        end
      end
      ST_ACT: begin
        ram_we     = (req_cmd == CMD_UPDATE);
        state_next = ST_RESP;
      end
      ST_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      replace_ptr <= '0;
      chk_pend    <= 1'b0;
      issue_idx   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          chk_pend  <= 1'b0;
          issue_idx <= '0;
        end
        ST_SCAN: begin
          chk_pend <= 1'b1;
          if (issue_idx != LAST_IDX) begin
            issue_idx <= issue_idx + 1'b1;
          end
        end
        ST_ACT: begin
          chk_pend <= 1'b0;
          if (req_cmd == CMD_UPDATE) begin
            if (!hit) begin
              entry_valid[replace_ptr] <= 1'b1;
              replace_ptr <= (replace_ptr == LAST_IDX) ? '0 : replace_ptr + 1'b1;
            end
          end else if (hit && stale) begin
            entry_valid[slot] <= 1'b0;
          end
        end
        default: begin
          chk_pend <= 1'b0;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          req_cmd   <= cmd;
          req_iface <= iface_index;
          req_ip    <= ip_addr;
          req_mac   <= new_mac;
          req_now   <= now_ticks;
        end
        hit <= 1'b0;
      end
      ST_SCAN: begin
        chk_idx <= issue_idx;
        if (key_match) begin
          hit       <= 1'b1;
          slot      <= chk_idx;
          hit_mac   <= rd_entry.mac;
          hit_stamp <= rd_entry.stamp;
        end
      end
      ST_ACT: begin
        if (req_cmd == CMD_UPDATE) begin
          found   <= hit;
          expired <= 1'b0;
          mac_out <= '0;
        end else begin
          found   <= hit && !stale;
          expired <= hit && stale;
          mac_out <= (hit && !stale) ? hit_mac : '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### verif/arp_cache_lookup_update_chk.sv
`timescale 1ns / 100ps

module arp_cache_lookup_update_chk import acl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               cmd,
  input  logic [IFACE_W-1:0] iface_index,
  input  logic [IP_W-1:0]    ip_addr,
  input  logic [MAC_W-1:0]   new_mac,
  input  logic [TICK_W-1:0]  now_ticks,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               found,
  input  logic               expired,
  input  logic [MAC_W-1:0]   mac_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 replies_due
);

  typedef struct packed {
    logic             found;
    logic             expired;
    logic [MAC_W-1:0] mac;
  } reply_t;

  logic              slot_live  [ENTRIES];
  logic [IFACE_W-1:0] slot_iface [ENTRIES];
  logic [IP_W-1:0]   slot_ip    [ENTRIES];
  logic [MAC_W-1:0]  slot_mac   [ENTRIES];
  logic [TICK_W-1:0] slot_stamp [ENTRIES];
  logic [IDX_W-1:0]  rr_ptr;
  logic [TICK_W-1:0] ttl;
  logic              timer_on;

  reply_t awaited_replies[$];

  // first live match wins; update refreshes or takes the round-robin slot
  function automatic reply_t predict_reply(input logic op, input logic [IFACE_W-1:0] ifc,
                                           input logic [IP_W-1:0] ip,
                                           input logic [MAC_W-1:0] mac,
                                           input logic [TICK_W-1:0] now);
    int                hit;
    reply_t            r;
    logic [TICK_W-1:0] age;
    hit = -1;
    r = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && slot_live[i] && slot_iface[i] == ifc && slot_ip[i] == ip) hit = i;
    end
    if (op == CMD_UPDATE) begin
      if (hit >= 0) begin
        slot_mac[hit] = mac;
        slot_stamp[hit] = timer_on ? now : '0;
        r.found = 1'b1;
      end else begin
        slot_iface[rr_ptr] = ifc;
        slot_ip[rr_ptr] = ip;
        slot_mac[rr_ptr] = mac;
        slot_stamp[rr_ptr] = timer_on ? now : '0;
        slot_live[rr_ptr] = 1'b1;
        rr_ptr = (rr_ptr == LAST_IDX) ? '0 : rr_ptr + 1'b1;
      end
    end else if (hit >= 0) begin
      age = now - slot_stamp[hit];
      if (timer_on && age > ttl) begin
        slot_live[hit] = 1'b0;
        r.expired = 1'b1;
      end else begin
        r.found = 1'b1;
        r.mac = slot_mac[hit];
      end
    end
    return r;
  endfunction

  task automatic check_field(input string what, input logic [MAC_W-1:0] want,
                             input logic [MAC_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_live[i] = 1'b0;
        slot_iface[i] = '0;
        slot_ip[i] = '0;
        slot_mac[i] = '0;
        slot_stamp[i] = '0;
      end
      rr_ptr = '0;
      ttl = '0;
      timer_on = 1'b0;
      awaited_replies.delete();
      fail_count = 0;
      replies_due <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[3] == REG_TTL) ttl = pwdata[TICK_W-1:0];
        else timer_on = pwdata[0];
      end
      if (in_valid && in_ready)
        awaited_replies.push_back(predict_reply(cmd, iface_index, ip_addr, new_mac,
                                                now_ticks));
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: unexpected reply, expected none, got found %b expired %b mac %h",
                   $time, found, expired, mac_out);
          fail_count++;
        end else begin
          want = awaited_replies.pop_front();
          check_field("found", MAC_W'(want.found), MAC_W'(found));
          check_field("expired", MAC_W'(want.expired), MAC_W'(expired));
          check_field("mac_out", want.mac, mac_out);
        end
      end
      replies_due <= awaited_replies.size();
    end
  end

endmodule

### verif/arp_cache_lookup_update_top_tb.sv
`timescale 1ns / 100ps

module arp_cache_lookup_update_top_tb import acl_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int POOL           = 20;
  localparam logic [PADDR_W-1:0] ADDR_TTL    = PADDR_W'({REG_TTL, 3'b000});
  localparam logic [PADDR_W-1:0] ADDR_EXPIRY = PADDR_W'({REG_EXPIRY, 3'b000});

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               cmd = CMD_UPDATE;
  logic [IFACE_W-1:0] iface_index = '0;
  logic [IP_W-1:0]    ip_addr = '0;
  logic [MAC_W-1:0]   new_mac = '0;
  logic [TICK_W-1:0]  now_ticks = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               found;
  logic               expired;
  logic [MAC_W-1:0]   mac_out;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 fail_count;
  int                 replies_due;

  logic               quiet = 1'b0;
  logic               long_hold_req = 1'b0;
  logic [IFACE_W-1:0] key_iface [POOL];
  logic [IP_W-1:0]    key_ip    [POOL];

  arp_cache_lookup_update_top i_dut (.*);

  arp_cache_lookup_update_chk i_chk (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // result side: random stalls, long hold-off on request
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        long_hold_req = 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (psel && penable && pwrite && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_req(input logic op, input logic [IFACE_W-1:0] ifc,
                          input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac,
                          input logic [TICK_W-1:0] now);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    iface_index <= ifc;
    ip_addr <= ip;
    new_mac <= mac;
    now_ticks <= now;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic [TICK_W-1:0] ttl, input logic en);
    wait_drain();
    cfg_write(ADDR_TTL, PDATA_W'(ttl));
    cfg_write(ADDR_EXPIRY, PDATA_W'(en));
  endtask

  // mostly keys from a pool a bit larger than the cache, ticks advancing
  task automatic run_phase(input logic [TICK_W-1:0] ttl, input logic en,
                           input logic [TICK_W-1:0] start, input int unsigned step,
                           input int n, input logic hold, input logic pause);
    logic [TICK_W-1:0]  tick;
    logic [TICK_W-1:0]  now;
    logic [IFACE_W-1:0] ifc;
    logic [IP_W-1:0]    ip;
    logic               op;
    int                 pick;
    set_mode(ttl, en);
    tick = start;
    if (hold) long_hold_req = 1'b1;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, POOL - 1);
      ifc = key_iface[pick];
      ip = key_ip[pick];
      if ($urandom_range(0, 9) == 0) begin
        ifc = IFACE_W'($urandom);
        ip = $urandom;
      end
      op = ($urandom_range(0, 1) == 1) ? CMD_LOOKUP : CMD_UPDATE;
      tick = tick + TICK_W'($urandom_range(0, step));
      now = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : tick;
      send_req(op, ifc, ip, MAC_W'({$urandom, $urandom}), now);
      if (pause && k == n / 2) wait_drain();
    end
  endtask

  initial begin
    for (int i = 0; i < POOL; i++) begin
      key_iface[i] = IFACE_W'($urandom_range(0, 3));
      key_ip[i] = $urandom;
    end
    key_ip[0] = '0;
    key_ip[1] = '1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // timer off: stamps stay 0, nothing ages out
    send_req(CMD_LOOKUP, 2'd0, '0, '0, '0);
    send_req(CMD_UPDATE, 2'd0, '0, '0, '1);
    send_req(CMD_UPDATE, 2'd3, '1, '1, '0);
    send_req(CMD_LOOKUP, 2'd3, '1, '0, '1);
    send_req(CMD_LOOKUP, 2'd2, '1, '1, '0);
    send_req(CMD_UPDATE, 2'd0, '0, 48'h0123_4567_89ab, 64'd77);
    send_req(CMD_LOOKUP, 2'd0, '0, '0, '1);

    // zero ttl: any nonzero age expires
    set_mode('0, 1'b1);
    send_req(CMD_UPDATE, 2'd1, 32'h0a00_0001, 48'hfeed_0000_0001, 64'd100);
    send_req(CMD_LOOKUP, 2'd1, 32'h0a00_0001, '0, 64'd100);
    send_req(CMD_LOOKUP, 2'd1, 32'h0a00_0001, '0, 64'd101);
    send_req(CMD_LOOKUP, 2'd1, 32'h0a00_0001, '0, 64'd101);
    send_req(CMD_LOOKUP, 2'd0, '0, '0, 64'd5);

    // max ttl, age wraps through zero
    set_mode('1, 1'b1);
    send_req(CMD_UPDATE, 2'd2, 32'hc0a8_0001, 48'h8000_0000_0000, 64'hffff_ffff_ffff_fff0);
    send_req(CMD_LOOKUP, 2'd2, 32'hc0a8_0001, '1, 64'd5);
    send_req(CMD_LOOKUP, 2'd3, '1, '0, 64'h8000_0000_0000_0000);

    run_phase(64'd40, 1'b1, {$urandom, $urandom}, 8, 120, 1'b1, 1'b0);
    run_phase('1, 1'b1, 64'hffff_ffff_ffff_f448, 50, 110, 1'b0, 1'b1);
    run_phase({$urandom, $urandom}, 1'b0, {$urandom, $urandom}, 1000, 110, 1'b0, 1'b0);
    run_phase('0, 1'b1, {$urandom, $urandom}, 1, 110, 1'b0, 1'b0);
    run_phase(64'd1000, 1'b1, 64'hffff_ffff_ffff_b1e0, 300, 120, 1'b0, 1'b0);
    quiet = 1'b1;
    run_phase(TICK_W'($urandom_range(0, 4095)), 1'b1, {$urandom, $urandom}, 200, 130,
              1'b0, 1'b0);

    wait_drain();
    repeat (ENTRIES + 8) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
